// ===== rtl/tea_pkg.sv =====
// Package for the TEA pair decryptor: item types, fixed key sets, round constants.
// Shared by tea_pair_decrypt_top; no dependencies.
package tea_pkg;

	localparam int unsigned ROUNDS  = 32;
	localparam int unsigned NSTAGES = 2 * ROUNDS;

	localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;

	localparam logic [1:0] KW0 = 2'd0;
	localparam logic [1:0] KW1 = 2'd1;
	localparam logic [1:0] KW2 = 2'd2;
	localparam logic [1:0] KW3 = 2'd3;

	localparam logic [31:0] KEY_SET0 [4] = '{
		32'h7AA9648F, 32'h7FAE6994, 32'hC0EFAAD5, 32'h42712C57
	};
	localparam logic [31:0] KEY_SET1 [4] = '{
		32'h09F4FBBD, 32'h9681884A, 32'h352027E9, 32'hF3DEE5A7
	};

	typedef struct packed {
		logic [31:0] enc_addr;
		logic [31:0] enc_value;
		logic        key_select;
	} cipher_item_t;

	typedef struct packed {
		logic [31:0] plain_addr;
		logic [31:0] plain_value;
	} plain_item_t;

	function automatic logic [31:0] key_word(input logic sel, input logic [1:0] idx);
		key_word = sel ? KEY_SET1[idx] : KEY_SET0[idx];
	endfunction

	// sum used by round r (counted from 0), wraps mod 2^32
	function automatic logic [31:0] round_sum(input int unsigned r);
		logic [63:0] prod;
		prod = 64'(ROUNDS - r) * 64'(TEA_DELTA);
		round_sum = prod[31:0];
	endfunction

	function automatic logic [31:0] tea_mix(input logic [31:0] w, input logic [31:0] sum,
		input logic [31:0] ka, input logic [31:0] kb);
		tea_mix = ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
	endfunction

endpackage

// ===== rtl/tea_pair_decrypt_top.sv =====
// Top level of the TEA pair decryptor: fully unrolled half-round pipeline.
// Depends on tea_pkg.
//
// Decrypts one (address, value) word pair per cycle, while the output is not
// stalled, under one of two fixed 128-bit keys. Each of the 32 rounds is split
// into two register stages (value half, then address half), giving 2*ROUNDS =
// 64 register stages. The first stage loads at the edge that accepts an item,
// and the result is offered from the last stage. A new item may be accepted
// every cycle unless the result stage holds an item that is not taken. When
// the result is not taken, the whole pipeline holds; the result register is
// the last stage, so items behind it keep their place and nothing is lost.
module tea_pair_decrypt_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cipher_valid,
	output logic                  cipher_ready,
	input  tea_pkg::cipher_item_t cipher,
	output logic                  result_valid,
	input  logic                  result_ready,
	output tea_pkg::plain_item_t  result
);
	import tea_pkg::*;

	logic               adv;
	logic [NSTAGES:1]   valid_s;
	logic [31:0]        addr_s  [NSTAGES:1];
	logic [31:0]        value_s [NSTAGES:1];
	logic               ksel_s  [NSTAGES:1];

	assign adv          = !valid_s[NSTAGES] || result_ready;
	assign cipher_ready = adv;
	assign result_valid = valid_s[NSTAGES];
	assign result.plain_addr  = addr_s[NSTAGES];
	assign result.plain_value = value_s[NSTAGES];

	for (genvar k = 0; k < NSTAGES; k++) begin : g_stage
		localparam logic [31:0] SUM = round_sum(k / 2);
		logic        src_valid;
		logic [31:0] src_addr;
		logic [31:0] src_value;
		logic        src_ksel;
		logic [31:0] nxt_addr;
		logic [31:0] nxt_value;

		if (k == 0) begin : g_src_in
			assign src_valid = cipher_valid;
			assign src_addr  = cipher.enc_addr;
			assign src_value = cipher.enc_value;
			assign src_ksel  = cipher.key_select;
		end else begin : g_src_reg
			assign src_valid = valid_s[k];
			assign src_addr  = addr_s[k];
			assign src_value = value_s[k];
			assign src_ksel  = ksel_s[k];
		end

		if (k % 2 == 0) begin : g_value_half
			always_comb begin
				nxt_addr  = src_addr;
				nxt_value = src_value - tea_mix(src_addr, SUM,
					key_word(src_ksel, KW2), key_word(src_ksel, KW3));
			end
		end else begin : g_addr_half
			always_comb begin
				nxt_value = src_value;
				nxt_addr  = src_addr - tea_mix(src_value, SUM,
					key_word(src_ksel, KW0), key_word(src_ksel, KW1));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				addr_s[k+1]  <= nxt_addr;
				value_s[k+1] <= nxt_value;
				ksel_s[k+1]  <= src_ksel;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid && cipher_ready |=> valid_s[1])
		else $error("accepted item did not enter first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s))
		else $error("pipeline valids moved during stall");

	a_last_shift: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s[NSTAGES] == $past(valid_s[NSTAGES-1]))
		else $error("result stage valid did not follow previous stage");

	a_ksel_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s[NSTAGES-1] |=> ksel_s[NSTAGES] == $past(ksel_s[NSTAGES-1]))
		else $error("key select lost between last stages");
`endif

endmodule
